>>> rtl/hsl2rgb_pkg.sv
// Shared constants and types for the HSL to RGB converter.
// Depends on nothing; every other file of the block refers to it by scoped names.

package hsl2rgb_pkg;

   // Default number of fraction bits of the unit-scaled channels
   localparam int FRACTION_BITS_DEF = 16;

   // Hue in signed 1/64 degree units
   localparam int HUE_W       = 16;
   localparam int HUE_RED_W   = 15;     // reduced hue, 0 .. HUE_FULL-1
   localparam int HUE_POS_W   = 13;     // position within a sector pair
   localparam int HUE_WT_W    = 12;     // weight 0 .. HUE_SECTOR
   localparam int HUE_FULL    = 23040;  // 360 degrees
   localparam int HUE_SECTOR  = 3840;   // 60 degrees

   // Sector width split as a power of two times an odd factor
   localparam int SECTOR_SHIFT = 8;
   localparam int SECTOR_ODD   = 15;

   // Sector codes, named after the hue span they cover
   localparam logic [2:0] SEC_RED_YELLOW    = 3'd0;
   localparam logic [2:0] SEC_YELLOW_GREEN  = 3'd1;
   localparam logic [2:0] SEC_GREEN_CYAN    = 3'd2;
   localparam logic [2:0] SEC_CYAN_BLUE     = 3'd3;
   localparam logic [2:0] SEC_BLUE_MAGENTA  = 3'd4;
   localparam logic [2:0] SEC_MAGENTA_RED   = 3'd5;

   // Load enables for the two stages of the secondary value scaler
   typedef struct packed {
      logic mul;
      logic rcp;
   } stage_en_type;

endpackage

>>> rtl/hsl2rgb_if.sv
// Request and response channel interfaces of the HSL to RGB converter.
// Depends on hsl2rgb_pkg for the default channel scale.

interface hsl_req_if #(
   parameter int FRACTION_BITS = hsl2rgb_pkg::FRACTION_BITS_DEF
);
   logic                                 valid;
   logic                                 ready;
   logic signed [hsl2rgb_pkg::HUE_W-1:0] hue;
   logic [FRACTION_BITS:0]               saturation;
   logic [FRACTION_BITS:0]               lightness;

   modport source (output valid, output hue, output saturation, output lightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input lightness,
                   output ready);
endinterface

interface hsl_rsp_if #(
   parameter int FRACTION_BITS = hsl2rgb_pkg::FRACTION_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [FRACTION_BITS:0] red;
   logic [FRACTION_BITS:0] green;
   logic [FRACTION_BITS:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/hsl_to_rgb_converter.sv
// HSL to RGB converter, top level: five-stage pipeline with valid bits and stall control.
// Depends on hsl2rgb_pkg, the channel interfaces and hsl2rgb_xscale.
//
// Usage:
//   Requests arrive on req_chan (hue in signed 1/64 degree, saturation and lightness
//   scaled so that 2^FRACTION_BITS is one); a request is taken on a clock edge with
//   valid and ready both high. Each request gives exactly one response on rsp_chan
//   with red, green and blue in the same unit scale.
//   A request passes stage 1, which loads at the edge that accepts it, then stages two,
//   three and four, and reaches rsp_chan from the output register, stage 5.
//   Throughput is one request per cycle while rsp_chan.ready stays high; stages 2,
//   3 and 4 each hold one multiplier (chroma, weighting and reciprocal) and set the clock.
//   Each stage advances when it is empty or the stage after it advances, so bubbles
//   are squeezed out and new requests are taken while a response waits at the output.
//   When the receiver holds ready low, the pipeline fills up and then req_chan.ready
//   drops; nothing is lost or repeated.
//   Synchronous reset clears all valid bits; the data registers are not reset.

module hsl_to_rgb_converter #(
   parameter int FRACTION_BITS = hsl2rgb_pkg::FRACTION_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   hsl_req_if.sink   req_chan,
   hsl_rsp_if.source rsp_chan
);

   localparam int CW    = FRACTION_BITS + 1;
   localparam int HRW   = hsl2rgb_pkg::HUE_RED_W;
   localparam int HPW   = hsl2rgb_pkg::HUE_POS_W;
   localparam int HWW   = hsl2rgb_pkg::HUE_WT_W;
   localparam int HXW   = hsl2rgb_pkg::HUE_W + 1;
   localparam logic [CW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   localparam logic signed [HXW-1:0] HUE_FULL_S  = HXW'(hsl2rgb_pkg::HUE_FULL);
   localparam logic signed [HXW-1:0] HUE_NFULL_S = -HXW'(hsl2rgb_pkg::HUE_FULL);
   localparam logic signed [HXW-1:0] HUE_TWO_S   = HXW'(2 * hsl2rgb_pkg::HUE_FULL);
   localparam logic [HRW-1:0] SEC_B1 = HRW'(1 * hsl2rgb_pkg::HUE_SECTOR);
   localparam logic [HRW-1:0] SEC_B2 = HRW'(2 * hsl2rgb_pkg::HUE_SECTOR);
   localparam logic [HRW-1:0] SEC_B3 = HRW'(3 * hsl2rgb_pkg::HUE_SECTOR);
   localparam logic [HRW-1:0] SEC_B4 = HRW'(4 * hsl2rgb_pkg::HUE_SECTOR);
   localparam logic [HRW-1:0] SEC_B5 = HRW'(5 * hsl2rgb_pkg::HUE_SECTOR);
   localparam logic [HPW-1:0] HALF_PAIR = HPW'(hsl2rgb_pkg::HUE_SECTOR);
   localparam logic [HWW-1:0] SEC_WT    = HWW'(hsl2rgb_pkg::HUE_SECTOR);

   // Pipeline control
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;
   hsl2rgb_pkg::stage_en_type xs_en;

   // Stage 1 signals
   logic [CW-1:0]          sat_cl, lig_cl;
   logic [CW:0]            twol, one_ext, lig_dev;
   logic [CW-1:0]          onemd_in, onemd_ff, sat1_ff, lig1_ff;
   logic signed [HXW-1:0]  hue_ext, hue_wrap;
   logic [HRW-1:0]         hue_in, hue1_ff;

   // Stage 2 signals
   logic [2*CW-1:0]        chroma_prod;
   logic [CW-1:0]          chroma2_in, chroma2_ff, lig2_ff;
   logic [2:0]             sector2_in, sector2_ff;
   logic [HRW-1:0]         pair_base;
   logic [HPW-1:0]         pos, tdist;
   logic [HWW-1:0]         wt2_in, wt2_ff;

   // Stage 3 and 4 signals
   logic [CW-1:0]          m3_in, chroma3_ff, m3_ff, chroma4_ff, m4_ff;
   logic [2:0]             sector3_ff, sector4_ff;
   logic [CW-1:0]          x4;

   // Stage 5 signals
   logic [CW-1:0]          r1, g1, b1;
   logic [CW-1:0]          red_ff, green_ff, blue_ff;

   // Advance a stage when it is empty or its successor advances
   always_comb begin
      en5 = !v5_ff || rsp_chan.ready;
      en4 = !v4_ff || en5;
      en3 = !v3_ff || en4;
      en2 = !v2_ff || en3;
      en1 = !v1_ff || en2;
      xs_en.mul = en3;
      xs_en.rcp = en4;
   end

   assign req_chan.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_chan.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // Stage 1: clamp to one, form 1 - |2L - 1|, wrap the hue into one turn
   always_comb begin
      sat_cl   = (req_chan.saturation > ONE) ? ONE : req_chan.saturation;
      lig_cl   = (req_chan.lightness > ONE) ? ONE : req_chan.lightness;
      twol     = {lig_cl, 1'b0};
      one_ext  = {1'b0, ONE};
      lig_dev  = (twol >= one_ext) ? (twol - one_ext) : (one_ext - twol);
      onemd_in = ONE - lig_dev[CW-1:0];

      hue_ext = HXW'(req_chan.hue);
      if (hue_ext < HUE_NFULL_S) begin
         hue_wrap = hue_ext + HUE_TWO_S;
      end else if (hue_ext < 0) begin
         hue_wrap = hue_ext + HUE_FULL_S;
      end else if (hue_ext >= HUE_FULL_S) begin
         hue_wrap = hue_ext - HUE_FULL_S;
      end else begin
         hue_wrap = hue_ext;
      end
      hue_in = hue_wrap[HRW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         onemd_ff <= onemd_in;
         sat1_ff  <= sat_cl;
         lig1_ff  <= lig_cl;
         hue1_ff  <= hue_in;
      end
   end

   // Stage 2: chroma product, sector and weight within the sector pair
   always_comb begin
      chroma_prod = (2*CW)'(onemd_ff) * (2*CW)'(sat1_ff);
      chroma2_in  = chroma_prod[FRACTION_BITS +: CW];

      if (hue1_ff >= SEC_B5) begin
         sector2_in = hsl2rgb_pkg::SEC_MAGENTA_RED;
      end else if (hue1_ff >= SEC_B4) begin
         sector2_in = hsl2rgb_pkg::SEC_BLUE_MAGENTA;
      end else if (hue1_ff >= SEC_B3) begin
         sector2_in = hsl2rgb_pkg::SEC_CYAN_BLUE;
      end else if (hue1_ff >= SEC_B2) begin
         sector2_in = hsl2rgb_pkg::SEC_GREEN_CYAN;
      end else if (hue1_ff >= SEC_B1) begin
         sector2_in = hsl2rgb_pkg::SEC_YELLOW_GREEN;
      end else begin
         sector2_in = hsl2rgb_pkg::SEC_RED_YELLOW;
      end

      if (hue1_ff >= SEC_B4) begin
         pair_base = SEC_B4;
      end else if (hue1_ff >= SEC_B2) begin
         pair_base = SEC_B2;
      end else begin
         pair_base = '0;
      end
      pos    = HPW'(hue1_ff - pair_base);
      tdist  = (pos >= HALF_PAIR) ? (pos - HALF_PAIR) : (HALF_PAIR - pos);
      wt2_in = SEC_WT - tdist[HWW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         chroma2_ff <= chroma2_in;
         lig2_ff    <= lig1_ff;
         sector2_ff <= sector2_in;
         wt2_ff     <= wt2_in;
      end
   end

   // Stages 3 and 4: scale chroma by the weight; carry offset and sector alongside
   hsl2rgb_xscale #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_xscale (
      .clock    (clock),
      .stage_en (xs_en),
      .chroma   (chroma2_ff),
      .weight   (wt2_ff),
      .x_value  (x4)
   );

   assign m3_in = lig2_ff - (chroma2_ff >> 1);

   always_ff @(posedge clock) begin
      if (en3) begin
         chroma3_ff <= chroma2_ff;
         m3_ff      <= m3_in;
         sector3_ff <= sector2_ff;
      end
      if (en4) begin
         chroma4_ff <= chroma3_ff;
         m4_ff      <= m3_ff;
         sector4_ff <= sector3_ff;
      end
   end

   // Stage 5: route chroma and x by sector, add the offset, hold for the receiver
   always_comb begin
      case (sector4_ff)
         hsl2rgb_pkg::SEC_RED_YELLOW: begin
            r1 = chroma4_ff; g1 = x4;         b1 = '0;
         end
         hsl2rgb_pkg::SEC_YELLOW_GREEN: begin
            r1 = x4;         g1 = chroma4_ff; b1 = '0;
         end
         hsl2rgb_pkg::SEC_GREEN_CYAN: begin
            r1 = '0;         g1 = chroma4_ff; b1 = x4;
         end
         hsl2rgb_pkg::SEC_CYAN_BLUE: begin
            r1 = '0;         g1 = x4;         b1 = chroma4_ff;
         end
         hsl2rgb_pkg::SEC_BLUE_MAGENTA: begin
            r1 = x4;         g1 = '0;         b1 = chroma4_ff;
         end
         default: begin
            r1 = chroma4_ff; g1 = '0;         b1 = x4;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         red_ff   <= r1 + m4_ff;
         green_ff <= g1 + m4_ff;
         blue_ff  <= b1 + m4_ff;
      end
   end

   assign rsp_chan.valid = v5_ff;
   assign rsp_chan.red   = red_ff;
   assign rsp_chan.green = green_ff;
   assign rsp_chan.blue  = blue_ff;

endmodule

>>> rtl/hsl2rgb_xscale.sv
// Two-stage scaler for the secondary value: x = floor(chroma * w / 3840).
// Depends on hsl2rgb_pkg; stage enables come from the pipeline control in the top level.

module hsl2rgb_xscale #(
   parameter int FRACTION_BITS = hsl2rgb_pkg::FRACTION_BITS_DEF
) (
   input  logic                                 clock,
   input  hsl2rgb_pkg::stage_en_type            stage_en,
   input  logic [FRACTION_BITS:0]               chroma,
   input  logic [hsl2rgb_pkg::HUE_WT_W-1:0]     weight,
   output logic [FRACTION_BITS:0]               x_value
);

   localparam int CW     = FRACTION_BITS + 1;
   localparam int PROD_W = CW + hsl2rgb_pkg::HUE_WT_W;
   localparam int Q_W    = FRACTION_BITS + 4;      // holds up to 15 * ONE
   localparam int K_W    = FRACTION_BITS + 5;
   localparam int RSHIFT = FRACTION_BITS + 8;      // Q_W plus four guard bits
   localparam longint unsigned K_FULL =
      ((64'd1 << RSHIFT) + hsl2rgb_pkg::SECTOR_ODD - 1) / hsl2rgb_pkg::SECTOR_ODD;
   localparam logic [K_W-1:0] RECIP = K_W'(K_FULL);

   logic [PROD_W-1:0]  prod;
   logic [Q_W-1:0]     quot_in, quot_ff;
   logic [Q_W+K_W-1:0] scaled;
   logic [CW-1:0]      x_in, x_ff;

   // Multiply by the weight and drop the power-of-two part of the sector width
   always_comb begin
      prod    = PROD_W'(chroma) * PROD_W'(weight);
      quot_in = prod[hsl2rgb_pkg::SECTOR_SHIFT +: Q_W];
   end

   always_ff @(posedge clock) begin
      if (stage_en.mul) begin
         quot_ff <= quot_in;
      end
   end

   // Divide by fifteen through an exact reciprocal multiply
   always_comb begin
      scaled = (Q_W + K_W)'(quot_ff) * (Q_W + K_W)'(RECIP);
      x_in   = scaled[RSHIFT +: CW];
   end

   always_ff @(posedge clock) begin
      if (stage_en.rcp) begin
         x_ff <= x_in;
      end
   end

   assign x_value = x_ff;

endmodule

>>> tb/hsl_to_rgb_converter_checker.sv
`timescale 1ns / 1ps
// Response checker for the HSL to RGB converter: watches both channels, predicts
// each response from its accepted request and compares red, green and blue.
// Depends on hsl2rgb_pkg and the channel interfaces of hsl2rgb_if.sv.

module hsl_to_rgb_converter_checker #(
   parameter int FRACTION_BITS = hsl2rgb_pkg::FRACTION_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   hsl_req_if   req_mon,
   hsl_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   outstanding_count
);
   import hsl2rgb_pkg::*;

   typedef struct packed {
      logic [FRACTION_BITS:0] red;
      logic [FRACTION_BITS:0] green;
      logic [FRACTION_BITS:0] blue;
   } rgb_type;

   rgb_type expected_rgb[$];

   // Work out the colour one request should give
   function automatic rgb_type predict_rgb(input logic signed [HUE_W-1:0] hue,
                                           input logic [FRACTION_BITS:0]  sat,
                                           input logic [FRACTION_BITS:0]  lum);
      longint unsigned unit_v, s, l, twol, lig_dev, chroma, x, m, r1, g1, b1;
      int              h, pos, t;
      logic [2:0]      sector;
      rgb_type         res;
      unit_v = 64'd1 << FRACTION_BITS;

      // Clamp saturation and lightness to one
      s = sat;
      l = lum;
      if (s > unit_v) s = unit_v;
      if (l > unit_v) l = unit_v;

      // Chroma from the distance of lightness to one half
      twol    = l << 1;
      lig_dev = (twol >= unit_v) ? twol - unit_v : unit_v - twol;
      chroma  = ((unit_v - lig_dev) * s) >> FRACTION_BITS;

      // Wrap the hue into one turn, negative values included
      h = hue;
      h = h % HUE_FULL;
      if (h < 0) h += HUE_FULL;

      // Secondary value from the position within a sector pair
      pos = h % (2 * HUE_SECTOR);
      t   = pos - HUE_SECTOR;
      if (t < 0) t = -t;
      x = (chroma * longint'(HUE_SECTOR - t)) / HUE_SECTOR;

      sector = 3'(h / HUE_SECTOR);
      case (sector)
         SEC_RED_YELLOW: begin
            r1 = chroma; g1 = x;      b1 = 0;
         end
         SEC_YELLOW_GREEN: begin
            r1 = x;      g1 = chroma; b1 = 0;
         end
         SEC_GREEN_CYAN: begin
            r1 = 0;      g1 = chroma; b1 = x;
         end
         SEC_CYAN_BLUE: begin
            r1 = 0;      g1 = x;      b1 = chroma;
         end
         SEC_BLUE_MAGENTA: begin
            r1 = x;      g1 = 0;      b1 = chroma;
         end
         default: begin
            r1 = chroma; g1 = 0;      b1 = x;
         end
      endcase

      // Lift all three channels by the offset
      m         = l - (chroma >> 1);
      res.red   = (FRACTION_BITS + 1)'(r1 + m);
      res.green = (FRACTION_BITS + 1)'(g1 + m);
      res.blue  = (FRACTION_BITS + 1)'(b1 + m);
      return res;
   endfunction

   task automatic check_channel(input string chan, input logic [FRACTION_BITS:0] want,
                                input logic [FRACTION_BITS:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s expected %0d actual %0d", $time, chan, want, got);
      end
   endtask

   // Compare each response with the oldest prediction, then queue the new request
   always @(posedge clock) begin : watch_channels
      rgb_type want;
      if (reset) begin
         expected_rgb.delete();
         mismatch_count    = 0;
         outstanding_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_rgb.size() == 0) begin
               mismatch_count++;
               $display("%0t: response expected none actual r %0d g %0d b %0d", $time,
                        rsp_mon.red, rsp_mon.green, rsp_mon.blue);
            end else begin
               want = expected_rgb.pop_front();
               check_channel("red", want.red, rsp_mon.red);
               check_channel("green", want.green, rsp_mon.green);
               check_channel("blue", want.blue, rsp_mon.blue);
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_rgb.push_back(predict_rgb(req_mon.hue, req_mon.saturation,
                                               req_mon.lightness));
         outstanding_count = expected_rgb.size();
      end
   end

endmodule

>>> tb/hsl_to_rgb_converter_tb.sv
`timescale 1ns / 1ps
// Testbench top for the HSL to RGB converter: drives requests with random gaps and
// response stalls, and gives the verdict from the checker's mismatch and outstanding counts.
// Depends on hsl2rgb_pkg, hsl2rgb_if.sv, the converter and its checker.

module hsl_to_rgb_converter_tb;
   import hsl2rgb_pkg::*;

   localparam int FB           = FRACTION_BITS_DEF;
   localparam int UNIT         = 1 << FB;
   localparam int RAW_MAX      = (1 << (FB + 1)) - 1;
   localparam int RANDOM_REQS  = 1826;
   localparam int MAX_GAP      = 17;
   localparam int HOLD_AT      = 500;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 400000;

   logic clock;
   logic reset;
   int   mismatches;
   int   outstanding;
   int   cycle_count = 0;
   int   responses_taken = 0;
   bit   no_idle = 1'b0;

   hsl_req_if #(.FRACTION_BITS(FB)) req_if ();
   hsl_rsp_if #(.FRACTION_BITS(FB)) rsp_if ();

   hsl_to_rgb_converter #(.FRACTION_BITS(FB)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   hsl_to_rgb_converter_checker #(.FRACTION_BITS(FB)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_if),
      .rsp_mon           (rsp_if),
      .mismatch_count    (mismatches),
      .outstanding_count (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Count cycles and stop a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Offer one request after a random gap and hold it until taken
   task automatic send_hsl(input int hue, input int sat, input int lum);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.hue        <= hue[HUE_W-1:0];
      req_if.saturation <= sat[FB:0];
      req_if.lightness  <= lum[FB:0];
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Mostly in range, sometimes exactly zero or one, sometimes above one
   function automatic int draw_unit();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(0, 1) ? UNIT : 0;
         1:       return $urandom_range(UNIT + 1, RAW_MAX);
         default: return $urandom_range(0, UNIT);
      endcase
   endfunction

   // Take responses after random stalls, with one long hold-off to back up the pipeline
   initial begin : take_responses
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (responses_taken == HOLD_AT)
            stall = HOLD_CYCLES;
         else
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         responses_taken++;
      end
   end

   initial begin : stimulus
      int hue_v;
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.hue           <= '0;
      req_if.saturation    <= '0;
      req_if.lightness     <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Sector starts and boundaries at full saturation, half lightness
      send_hsl(0, UNIT, UNIT / 2);
      send_hsl(HUE_SECTOR, UNIT, UNIT / 2);
      send_hsl(2 * HUE_SECTOR, UNIT, UNIT / 2);
      send_hsl(3 * HUE_SECTOR, UNIT, UNIT / 2);
      send_hsl(4 * HUE_SECTOR, UNIT, UNIT / 2);
      send_hsl(5 * HUE_SECTOR, UNIT, UNIT / 2);
      send_hsl(HUE_FULL - 1, UNIT, UNIT / 2);
      send_hsl(HUE_SECTOR / 2, UNIT, UNIT / 2);
      // Negative hues wrap, hue extremes
      send_hsl(-1, UNIT, UNIT / 2);
      send_hsl(-32768, UNIT, UNIT / 2);
      send_hsl(32767, UNIT, UNIT / 2);
      send_hsl(-HUE_FULL, UNIT, UNIT / 2);
      send_hsl(-HUE_SECTOR, UNIT, UNIT / 2);
      // Grey, black, white, and clamping above one
      send_hsl(5000, 0, UNIT / 2);
      send_hsl(5000, UNIT, 0);
      send_hsl(5000, UNIT, UNIT);
      send_hsl(5000, RAW_MAX, UNIT / 2);
      send_hsl(5000, UNIT + 1, 20000);
      send_hsl(13000, 40000, RAW_MAX);
      send_hsl(9000, UNIT + UNIT / 2, UNIT + 1);
      send_hsl(0, 0, 0);
      send_hsl(-17, RAW_MAX, RAW_MAX);
      send_hsl(21000, 1, 1);
      send_hsl(16000, UNIT - 1, UNIT - 1);

      // Random colours, every third stretch of 150 without idling
      for (int i = 0; i < RANDOM_REQS; i++) begin
         no_idle = ((i / 150) % 3) == 2;
         if ($urandom_range(0, 7) == 0)
            hue_v = (int'($urandom_range(0, 16)) - 8) * HUE_SECTOR
                    + int'($urandom_range(0, 2)) - 1;
         else
            hue_v = int'($urandom & 32'hFFFF);
         send_hsl(hue_v, draw_unit(), draw_unit());
      end
      no_idle = 1'b0;
      req_if.valid <= 1'b0;

      // Drain and give the verdict
      @(posedge clock);
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> filelist.f
rtl/hsl2rgb_pkg.sv
rtl/hsl2rgb_if.sv
rtl/hsl2rgb_xscale.sv
rtl/hsl_to_rgb_converter.sv
tb/hsl_to_rgb_converter_checker.sv
tb/hsl_to_rgb_converter_tb.sv
